### rtl/core/usb_endpoint_transfer_sequencer_defines.svh
// Assertion macros shared by the endpoint transfer sequencer RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef USB_ENDPOINT_TRANSFER_SEQUENCER_DEFINES_SVH
`define USB_ENDPOINT_TRANSFER_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define UETS_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UETS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/uets_pkg.sv
// Shared types and constants for the endpoint transfer sequencer.
// Depends on nothing; imported by every module of the block.
package uets_pkg;

   localparam int EP_SLOTS = 32;
   localparam int EP_W     = 5;
   localparam int EP_AW    = (EP_SLOTS > 1) ? $clog2(EP_SLOTS) : 1;

   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_AW    = $clog2(RSPQ_DEPTH);

   localparam logic [2:0] KIND_SET_MP    = 3'd0;
   localparam logic [2:0] KIND_START     = 3'd1;
   localparam logic [2:0] KIND_DONE      = 3'd2;
   localparam logic [2:0] KIND_SETUP     = 3'd3;
   localparam logic [2:0] KIND_BUS_RESET = 3'd4;

   localparam logic [1:0] ACT_ARM      = 2'd0;
   localparam logic [1:0] ACT_DELIVER  = 2'd1;
   localparam logic [1:0] ACT_SET_ADDR = 2'd2;

   localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
   localparam logic [7:0] REQ_SET_CONFIG  = 8'd9;
   localparam logic [9:0] EP0_MAX_PACKET  = 10'd64;

   typedef struct packed {
      logic [2:0]      kind;
      logic [EP_W-1:0] ep;
      logic [15:0]     len;
      logic [9:0]      plim;
      logic [9:0]      rlen;
      logic            set_addr;
      logic            set_cfg;
      logic [7:0]      addr;
   } cmd_type;

   typedef struct packed {
      logic [1:0]      action;
      logic [EP_W-1:0] target_endpoint;
      logic [9:0]      byte_count;
      logic            data_pid;
      logic            buffer_full;
      logic            last_buffer;
      logic [7:0]      device_address;
      logic            configured;
      logic            last_result;
   } rsp_type;

endpackage

### rtl/core/uets_front.sv
// Front end: takes request beats, drops the ones that do nothing, decodes the rest.
// Depends on uets_pkg.
module uets_front (
   input  logic                   push,
   output logic                   full,
   input  logic [2:0]             req_kind,
   input  logic [uets_pkg::EP_W-1:0] req_endpoint,
   input  logic [15:0]            req_transfer_length,
   input  logic [9:0]             req_packet_limit,
   input  logic [9:0]             req_received_length,
   input  logic [7:0]             req_request_code,
   input  logic [15:0]            req_request_value,
   input  logic                   q_full,
   output logic                   q_push,
   output uets_pkg::cmd_type      q_cmd
);
   import uets_pkg::*;

   logic ep_ok;
   logic keep;

   assign ep_ok = ({1'b0, req_endpoint} < (EP_W + 1)'(EP_SLOTS));

   always_comb begin
      q_cmd          = '0;
      q_cmd.kind     = req_kind;
      q_cmd.ep       = req_endpoint;
      q_cmd.len      = req_transfer_length;
      q_cmd.plim     = req_packet_limit;
      q_cmd.rlen     = req_received_length;
      q_cmd.set_addr = (req_request_code == REQ_SET_ADDRESS);
      q_cmd.set_cfg  = (req_request_code == REQ_SET_CONFIG);
      q_cmd.addr     = req_request_value[7:0];
      case (req_kind)
         KIND_SET_MP, KIND_START, KIND_DONE: begin
            keep = ep_ok;
         end
         KIND_SETUP: begin
            keep     = 1'b1;
            q_cmd.ep = '0;
         end
         KIND_BUS_RESET: begin
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign full   = q_full;
   assign q_push = push & ~q_full & keep;

endmodule

### rtl/core/uets_cmd_queue.sv
// Short command queue between the front end and the back end.
// Depends on uets_pkg.
module uets_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  uets_pkg::cmd_type wr_data,
   output logic              full_o,
   input  logic              rd_en,
   output logic              valid_o,
   output uets_pkg::cmd_type rd_data
);
   import uets_pkg::*;

   cmd_type              ent_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_AW:0]     count_ff, count_in;
   logic                 do_wr, do_rd;

   assign full_o  = (count_ff == (CMDQ_AW + 1)'(CMDQ_DEPTH));
   assign valid_o = (count_ff != '0);
   assign rd_data = ent_ff[rd_ptr_ff];
   assign do_wr   = wr_en & ~full_o;
   assign do_rd   = rd_en & valid_o;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (CMDQ_AW + 1)'(do_wr) - (CMDQ_AW + 1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         ent_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/core/uets_rsp_queue.sv
// Result queue: takes up to two results a cycle, hands out one a cycle while popped.
// Depends on uets_pkg.
module uets_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              wr_cnt,
   input  uets_pkg::rsp_type [1:0] wr_data,
   output logic                    room_o,
   input  logic                    pop,
   output logic                    empty,
   output uets_pkg::rsp_type       head
);
   import uets_pkg::*;

   rsp_type             ent_ff [RSPQ_DEPTH];
   logic [RSPQ_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_AW:0]    count_ff, count_in;
   logic                do_rd;

   assign empty  = (count_ff == '0);
   assign head   = ent_ff[rd_ptr_ff];
   assign room_o = (count_ff <= (RSPQ_AW + 1)'(RSPQ_DEPTH - 2));
   assign do_rd  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSPQ_AW'(wr_cnt);
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (RSPQ_AW + 1)'(wr_cnt) - (RSPQ_AW + 1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_cnt != 2'd0) begin
         ent_ff[wr_ptr_ff] <= wr_data[0];
      end
      if (wr_cnt == 2'd2) begin
         ent_ff[wr_ptr_ff + 1'b1] <= wr_data[1];
      end
   end

endmodule

### rtl/core/uets_back.sv
// Back end: endpoint tables, toggle bits and device state; carries out one command
// per read/execute pair. Depends on uets_pkg and the sequencer defines header.
module uets_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   input  uets_pkg::cmd_type       cmd_head,
   output logic                    cmd_pop,
   input  logic                    rsp_room,
   output logic [1:0]              rsp_cnt,
   output uets_pkg::rsp_type [1:0] rsp_wr
);
   import uets_pkg::*;
   `include "usb_endpoint_transfer_sequencer_defines.svh"

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic [15:0]          rem_mem [EP_SLOTS];
   logic [9:0]           mp_mem  [EP_SLOTS];
   logic [EP_SLOTS-1:0]  rem_vld_ff, rem_vld_in;
   logic [EP_SLOTS-1:0]  mp_vld_ff, mp_vld_in;

   logic                 state_ff, state_in;
   cmd_type              cmd_ff;
   logic [15:0]          rem_a_ff, rem_b_ff;
   logic [9:0]           mp_a_ff;
   logic                 rem_a_vld_ff, rem_b_vld_ff, mp_a_vld_ff;
   logic [EP_SLOTS-1:0]  tog_ff, tog_in, tog_base;
   logic [7:0]           paddr_ff, paddr_in;
   logic                 pend_ff, pend_in;
   logic                 cfg_ff, cfg_in;

   logic [EP_AW-1:0]     rd_addr, ep_ix;
   logic                 exec;
   logic [15:0]          rem_a, rem_b, arm_rem, chunk, new_rem;
   logic [9:0]           mp_a;
   logic                 rem_we, mp_we;
   logic                 arm_a, arm_b, set_addr_r, bus_rst, deliver;
   logic [2:0]           n_rsp;
   rsp_type              arm_a_rsp, arm_b_rsp, sa_rsp, del_rsp, first_rsp;

   assign cmd_pop = (state_ff == ST_IDLE) & cmd_valid & rsp_room;
   assign exec    = (state_ff == ST_EXEC);
   assign rd_addr = cmd_head.ep[EP_AW-1:0];
   assign ep_ix   = cmd_ff.ep[EP_AW-1:0];

   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = cmd_pop ? ST_EXEC : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // read the tables as the command leaves the queue
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff       <= cmd_head;
         rem_a_ff     <= rem_mem[rd_addr];
         mp_a_ff      <= mp_mem[rd_addr];
         rem_b_ff     <= rem_mem[EP_AW'(1)];
         rem_a_vld_ff <= rem_vld_ff[rd_addr];
         mp_a_vld_ff  <= mp_vld_ff[rd_addr];
         rem_b_vld_ff <= rem_vld_ff[EP_AW'(1)];
      end
      if (rem_we) begin
         rem_mem[ep_ix] <= new_rem;
      end
      if (mp_we) begin
         mp_mem[ep_ix] <= cmd_ff.plim;
      end
   end

   always_comb begin
      rem_a = rem_a_vld_ff ? rem_a_ff : 16'd0;
      rem_b = rem_b_vld_ff ? rem_b_ff : 16'd0;
      if (mp_a_vld_ff) begin
         mp_a = mp_a_ff;
      end else if (cmd_ff.ep inside {EP_W'(0), EP_W'(1)}) begin
         mp_a = EP0_MAX_PACKET;
      end else begin
         mp_a = 10'd0;
      end
      arm_rem = (cmd_ff.kind == KIND_START) ? cmd_ff.len : rem_a;
      chunk   = (arm_rem > {6'd0, mp_a}) ? {6'd0, mp_a} : arm_rem;
      new_rem = arm_rem - chunk;
   end

   always_comb begin
      rem_we     = 1'b0;
      mp_we      = 1'b0;
      arm_a      = 1'b0;
      arm_b      = 1'b0;
      set_addr_r = 1'b0;
      bus_rst    = 1'b0;
      deliver    = 1'b0;
      pend_in    = pend_ff;
      paddr_in   = paddr_ff;
      cfg_in     = cfg_ff;
      tog_base   = tog_ff;
      if (exec) begin
         case (cmd_ff.kind)
            KIND_SET_MP: begin
               mp_we = 1'b1;
            end
            KIND_START: begin
               arm_a  = (rem_a == 16'd0);
               rem_we = (rem_a == 16'd0);
            end
            KIND_DONE: begin
               if (rem_a != 16'd0) begin
                  arm_a  = 1'b1;
                  rem_we = 1'b1;
               end else if (cmd_ff.ep == EP_W'(0)) begin
                  set_addr_r = pend_ff;
                  pend_in    = 1'b0;
                  arm_b      = (rem_b == 16'd0);
               end else if (cmd_ff.ep > EP_W'(1)) begin
                  deliver = 1'b1;
               end
            end
            KIND_SETUP: begin
               tog_base[0] = 1'b1;
               if (cmd_ff.set_addr) begin
                  paddr_in = cmd_ff.addr;
                  pend_in  = 1'b1;
               end else if (cmd_ff.set_cfg) begin
                  cfg_in = 1'b1;
               end
               arm_a = (rem_a == 16'd0);
            end
            KIND_BUS_RESET: begin
               bus_rst = 1'b1;
               pend_in = 1'b0;
               cfg_in  = 1'b0;
            end
            default: begin
               arm_a = 1'b0;
            end
         endcase
      end
      tog_in = tog_base;
      if (arm_a) begin
         tog_in[ep_ix] = ~tog_base[ep_ix];
      end
      if (arm_b) begin
         tog_in[1] = ~tog_base[1];
      end
   end

   always_comb begin
      arm_a_rsp                 = '0;
      arm_a_rsp.action          = ACT_ARM;
      arm_a_rsp.target_endpoint = cmd_ff.ep;
      arm_a_rsp.byte_count      = chunk[9:0];
      arm_a_rsp.data_pid        = tog_base[ep_ix];
      arm_a_rsp.buffer_full     = ~cmd_ff.ep[0];
      arm_a_rsp.last_buffer     = ~cmd_ff.ep[0] & (new_rem == 16'd0);
      arm_a_rsp.configured      = cfg_in;

      arm_b_rsp                 = '0;
      arm_b_rsp.action          = ACT_ARM;
      arm_b_rsp.target_endpoint = EP_W'(1);
      arm_b_rsp.data_pid        = tog_base[1];
      arm_b_rsp.configured      = cfg_in;

      sa_rsp                    = '0;
      sa_rsp.action             = ACT_SET_ADDR;
      sa_rsp.device_address     = bus_rst ? 8'd0 : paddr_ff;
      sa_rsp.configured         = cfg_in;

      del_rsp                   = '0;
      del_rsp.action            = ACT_DELIVER;
      del_rsp.target_endpoint   = cmd_ff.ep;
      del_rsp.byte_count        = cmd_ff.rlen;
      del_rsp.configured        = cfg_in;

      if (set_addr_r | bus_rst) begin
         first_rsp = sa_rsp;
      end else if (deliver) begin
         first_rsp = del_rsp;
      end else if (arm_a) begin
         first_rsp = arm_a_rsp;
      end else begin
         first_rsp = arm_b_rsp;
      end

      n_rsp = 3'(set_addr_r) + 3'(bus_rst) + 3'(deliver) + 3'(arm_a) + 3'(arm_b);
      rsp_cnt = n_rsp[1:0];
      rsp_wr[0]             = first_rsp;
      rsp_wr[0].last_result = (n_rsp == 3'd1);
      rsp_wr[1]             = arm_b_rsp;
      rsp_wr[1].last_result = 1'b1;
   end

   always_comb begin
      rem_vld_in = rem_vld_ff;
      mp_vld_in  = mp_vld_ff;
      if (rem_we) begin
         rem_vld_in[ep_ix] = 1'b1;
      end
      if (mp_we) begin
         mp_vld_in[ep_ix] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rem_vld_ff <= '0;
         mp_vld_ff  <= '0;
         tog_ff     <= EP_SLOTS'(1);
         paddr_ff   <= '0;
         pend_ff    <= 1'b0;
         cfg_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rem_vld_ff <= rem_vld_in;
         mp_vld_ff  <= mp_vld_in;
         tog_ff     <= tog_in;
         paddr_ff   <= paddr_in;
         pend_ff    <= pend_in;
         cfg_ff     <= cfg_in;
      end
   end

   `UETS_ASSERT_NEXT(a_exec_one_cycle, clock, reset, state_ff == ST_EXEC, state_ff == ST_IDLE, "execute state held")
   `UETS_ASSERT_IMPLY(a_push_follows_pop, clock, reset, rsp_cnt != 2'd0, $past(cmd_pop), "result without command")
   `UETS_ASSERT_IMPLY(a_single_is_last, clock, reset, rsp_cnt == 2'd1, rsp_wr[0].last_result, "lone result not last")
   `UETS_ASSERT_IMPLY(a_pair_order, clock, reset, rsp_cnt == 2'd2, rsp_wr[1].last_result && !rsp_wr[0].last_result, "bad last marks on pair")

endmodule

### rtl/core/usb_endpoint_transfer_sequencer.sv
// Kept requests pass the command queue, a registered table read, an execute step and the
// result queue; one leaves the command queue only once the back end is back to idle and
// the result queue has room. Kept requests that give no result still take a slot. Up to
// two results per request drain at one per cycle, while popped, through a four-entry queue.
// Reset: synchronous; queues empty and tables read as reset values at once (no sweep).
module usb_endpoint_transfer_sequencer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [2:0]                req_kind,
   input  logic [uets_pkg::EP_W-1:0] req_endpoint,
   input  logic [15:0]               req_transfer_length,
   input  logic [9:0]                req_packet_limit,
   input  logic [9:0]                req_received_length,
   input  logic [7:0]                req_request_code,
   input  logic [15:0]               req_request_value,
   output logic                      empty,
   input  logic                      pop,
   output logic [1:0]                rsp_action,
   output logic [uets_pkg::EP_W-1:0] rsp_target_endpoint,
   output logic [9:0]                rsp_byte_count,
   output logic                      rsp_data_pid,
   output logic                      rsp_buffer_full,
   output logic                      rsp_last_buffer,
   output logic [7:0]                rsp_device_address,
   output logic                      rsp_configured,
   output logic                      rsp_last_result
);
   import uets_pkg::*;

   logic           q_push, q_full, q_valid, q_pop;
   cmd_type        q_cmd, q_head;
   logic           rsp_room;
   logic [1:0]     rsp_cnt;
   rsp_type [1:0]  rsp_wr;
   rsp_type        head;

   uets_front u_front (
      .push                (push),
      .full                (full),
      .req_kind            (req_kind),
      .req_endpoint        (req_endpoint),
      .req_transfer_length (req_transfer_length),
      .req_packet_limit    (req_packet_limit),
      .req_received_length (req_received_length),
      .req_request_code    (req_request_code),
      .req_request_value   (req_request_value),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_cmd               (q_cmd)
   );

   uets_cmd_queue u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_cmd),
      .full_o  (q_full),
      .rd_en   (q_pop),
      .valid_o (q_valid),
      .rd_data (q_head)
   );

   uets_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_head  (q_head),
      .cmd_pop   (q_pop),
      .rsp_room  (rsp_room),
      .rsp_cnt   (rsp_cnt),
      .rsp_wr    (rsp_wr)
   );

   uets_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_cnt  (rsp_cnt),
      .wr_data (rsp_wr),
      .room_o  (rsp_room),
      .pop     (pop),
      .empty   (empty),
      .head    (head)
   );

   assign rsp_action          = head.action;
   assign rsp_target_endpoint = head.target_endpoint;
   assign rsp_byte_count      = head.byte_count;
   assign rsp_data_pid        = head.data_pid;
   assign rsp_buffer_full     = head.buffer_full;
   assign rsp_last_buffer     = head.last_buffer;
   assign rsp_device_address  = head.device_address;
   assign rsp_configured      = head.configured;
   assign rsp_last_result     = head.last_result;

endmodule

### verif/testbench.sv
// Self-checking testbench for usb_endpoint_transfer_sequencer: directed and random
// endpoint traffic, with results predicted by a scoreboard class inside the top.
// Depends on uets_pkg and the sequencer RTL only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import uets_pkg::*;

   localparam logic [2:0] KIND_SPARE_MIN = 3'd5;
   localparam logic [2:0] KIND_SPARE_MAX = 3'd7;
   localparam int         QUIET_LIMIT    = 3000;
   localparam int         DRAIN_CYCLES   = 20;
   localparam int         PHASE_ITEMS    = 200;

   typedef struct packed {
      logic [2:0]      kind;
      logic [EP_W-1:0] ep;
      logic [15:0]     len;
      logic [9:0]      plim;
      logic [9:0]      rlen;
      logic [7:0]      code;
      logic [15:0]     value;
   } req_beat_t;

   class transfer_tracker;
      logic [15:0] left_bytes [EP_SLOTS];
      logic [9:0]  packet_cap [EP_SLOTS];
      logic [31:0] pid_bits;
      logic [7:0]  addr_latched;
      logic        addr_switch_due;
      logic        cfg_done;
      rsp_type     awaited [$];
      rsp_type     batch [$];
      int unsigned mismatches;

      function new();
         foreach (left_bytes[i]) begin
            left_bytes[i] = '0;
            packet_cap[i] = (i < 2) ? EP0_MAX_PACKET : '0;
         end
         pid_bits        = 32'd1;
         addr_latched    = '0;
         addr_switch_due = 1'b0;
         cfg_done        = 1'b0;
         mismatches      = 0;
      endfunction

      function void add_rsp(logic [1:0] act, logic [EP_W-1:0] ep, logic [9:0] cnt,
                            logic pid, logic full_b, logic last_b, logic [7:0] addr);
         rsp_type r;
         r                 = '0;
         r.action          = act;
         r.target_endpoint = ep;
         r.byte_count      = cnt;
         r.data_pid        = pid;
         r.buffer_full     = full_b;
         r.last_buffer     = last_b;
         r.device_address  = addr;
         batch.push_back(r);
      endfunction

      function void arm_next(logic [EP_W-1:0] ep);
         logic [15:0] rem;
         logic [9:0]  chunk;
         logic        pid;
         rem            = left_bytes[ep];
         chunk          = (rem > {6'd0, packet_cap[ep]}) ? packet_cap[ep] : rem[9:0];
         left_bytes[ep] = rem - {6'd0, chunk};
         pid            = pid_bits[ep];
         pid_bits[ep]   = ~pid_bits[ep];
         if (!ep[0]) begin
            add_rsp(ACT_ARM, ep, chunk, pid, 1'b1, left_bytes[ep] == 0, 8'd0);
         end else begin
            add_rsp(ACT_ARM, ep, chunk, pid, 1'b0, 1'b0, 8'd0);
         end
      endfunction

      function void start_xfer(logic [EP_W-1:0] ep, logic [15:0] len);
         if (left_bytes[ep] != 0) return;
         left_bytes[ep] = len;
         arm_next(ep);
      endfunction

      function void note_request(req_beat_t rq);
         logic ep_ok;
         ep_ok = rq.ep < EP_SLOTS;
         batch.delete();
         case (rq.kind)
            KIND_SET_MP: begin
               if (ep_ok) packet_cap[rq.ep] = rq.plim;
            end
            KIND_START: begin
               if (ep_ok) start_xfer(rq.ep, rq.len);
            end
            KIND_DONE: begin
               if (ep_ok) begin
                  if (left_bytes[rq.ep] != 0) begin
                     arm_next(rq.ep);
                  end else if (rq.ep == 0) begin
                     if (addr_switch_due) begin
                        addr_switch_due = 1'b0;
                        add_rsp(ACT_SET_ADDR, '0, '0, 1'b0, 1'b0, 1'b0, addr_latched);
                     end
                     start_xfer(5'd1, 16'd0);
                  end else if (rq.ep > 1) begin
                     add_rsp(ACT_DELIVER, rq.ep, rq.rlen, 1'b0, 1'b0, 1'b0, 8'd0);
                  end
               end
            end
            KIND_SETUP: begin
               pid_bits[0] = 1'b1;
               if (rq.code == REQ_SET_ADDRESS) begin
                  addr_latched    = rq.value[7:0];
                  addr_switch_due = 1'b1;
               end else if (rq.code == REQ_SET_CONFIG) begin
                  cfg_done = 1'b1;
               end
               start_xfer(5'd0, 16'd0);
            end
            KIND_BUS_RESET: begin
               addr_switch_due = 1'b0;
               cfg_done        = 1'b0;
               add_rsp(ACT_SET_ADDR, '0, '0, 1'b0, 1'b0, 1'b0, 8'd0);
            end
            default: ;
         endcase
         foreach (batch[i]) begin
            batch[i].configured  = cfg_done;
            batch[i].last_result = (i == batch.size() - 1);
            awaited.push_back(batch[i]);
         end
      endfunction

      function void report(string what, rsp_type want, rsp_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%s: expected %p, got %p", what, want, got);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            report("unexpected result", '0, got);
            return;
         end
         want = awaited.pop_front();
         if (got.action !== want.action || got.target_endpoint !== want.target_endpoint ||
             got.byte_count !== want.byte_count || got.data_pid !== want.data_pid ||
             got.buffer_full !== want.buffer_full || got.last_buffer !== want.last_buffer ||
             got.device_address !== want.device_address ||
             got.configured !== want.configured || got.last_result !== want.last_result)
            report("result mismatch", want, got);
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            push  = 1'b0;
   logic            full;
   logic [2:0]      req_kind = '0;
   logic [EP_W-1:0] req_endpoint = '0;
   logic [15:0]     req_transfer_length = '0;
   logic [9:0]      req_packet_limit = '0;
   logic [9:0]      req_received_length = '0;
   logic [7:0]      req_request_code = '0;
   logic [15:0]     req_request_value = '0;
   logic            empty;
   logic            pop = 1'b0;
   logic [1:0]      rsp_action;
   logic [EP_W-1:0] rsp_target_endpoint;
   logic [9:0]      rsp_byte_count;
   logic            rsp_data_pid;
   logic            rsp_buffer_full;
   logic            rsp_last_buffer;
   logic [7:0]      rsp_device_address;
   logic            rsp_configured;
   logic            rsp_last_result;

   transfer_tracker tracker = new();
   int unsigned     send_idle_pct  = 0;
   int unsigned     recv_stall_pct = 0;
   int unsigned     sent_items     = 0;
   int unsigned     quiet_cycles   = 0;

   usb_endpoint_transfer_sequencer i_dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_kind            (req_kind),
      .req_endpoint        (req_endpoint),
      .req_transfer_length (req_transfer_length),
      .req_packet_limit    (req_packet_limit),
      .req_received_length (req_received_length),
      .req_request_code    (req_request_code),
      .req_request_value   (req_request_value),
      .empty               (empty),
      .pop                 (pop),
      .rsp_action          (rsp_action),
      .rsp_target_endpoint (rsp_target_endpoint),
      .rsp_byte_count      (rsp_byte_count),
      .rsp_data_pid        (rsp_data_pid),
      .rsp_buffer_full     (rsp_buffer_full),
      .rsp_last_buffer     (rsp_last_buffer),
      .rsp_device_address  (rsp_device_address),
      .rsp_configured      (rsp_configured),
      .rsp_last_result     (rsp_last_result)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin : rsp_sink
      rsp_type got;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            got.action          = rsp_action;
            got.target_endpoint = rsp_target_endpoint;
            got.byte_count      = rsp_byte_count;
            got.data_pid        = rsp_data_pid;
            got.buffer_full     = rsp_buffer_full;
            got.last_buffer     = rsp_last_buffer;
            got.device_address  = rsp_device_address;
            got.configured      = rsp_configured;
            got.last_result     = rsp_last_result;
            tracker.check_response(got);
         end
         pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_beat_t rand_req(logic [2:0] kind, logic [EP_W-1:0] ep);
      req_beat_t r;
      r.kind  = kind;
      r.ep    = ep;
      r.len   = $urandom;
      r.plim  = $urandom;
      r.rlen  = $urandom;
      r.code  = $urandom;
      r.value = $urandom;
      return r;
   endfunction

   task automatic issue(input req_beat_t rq);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push                <= 1'b1;
      req_kind            <= rq.kind;
      req_endpoint        <= rq.ep;
      req_transfer_length <= rq.len;
      req_packet_limit    <= rq.plim;
      req_received_length <= rq.rlen;
      req_request_code    <= rq.code;
      req_request_value   <= rq.value;
      @(posedge clock);
      while (full) @(posedge clock);
      tracker.note_request(rq);
      if (rq.kind <= KIND_BUS_RESET) sent_items++;
   endtask

   task automatic set_packet(logic [EP_W-1:0] ep, logic [9:0] plim);
      req_beat_t r;
      r      = rand_req(KIND_SET_MP, ep);
      r.plim = plim;
      issue(r);
   endtask

   task automatic start_xfer(logic [EP_W-1:0] ep, logic [15:0] len);
      req_beat_t r;
      r     = rand_req(KIND_START, ep);
      r.len = len;
      issue(r);
   endtask

   task automatic setup_req(logic [7:0] code, logic [15:0] value);
      req_beat_t r;
      r       = rand_req(KIND_SETUP, $urandom);
      r.code  = code;
      r.value = value;
      issue(r);
   endtask

   // drain whatever is left on the endpoint, then send the closing done
   task automatic finish_xfer(logic [EP_W-1:0] ep);
      int guard;
      guard = 0;
      while (tracker.left_bytes[ep] != 0) begin
         if (guard == 8 && tracker.packet_cap[ep] < 10'd512)
            set_packet(ep, $urandom_range(512, 1023));
         issue(rand_req(KIND_DONE, ep));
         guard++;
      end
      issue(rand_req(KIND_DONE, ep));
   endtask

   task automatic run_transfer(logic [EP_W-1:0] ep);
      int pick;
      pick = $urandom_range(9);
      if ($urandom_range(3) == 0 || tracker.packet_cap[ep] == 0)
         set_packet(ep, (pick < 8) ? $urandom_range(1, 64) :
                        (pick == 8) ? 10'd0 : $urandom_range(65, 1023));
      pick = $urandom_range(9);
      start_xfer(ep, (pick < 7) ? $urandom_range(0, 300) :
                     (pick < 9) ? $urandom_range(0, 4000) : $urandom_range(0, 65535));
      finish_xfer(ep);
   endtask

   task automatic run_control();
      int pick;
      int guard;
      pick = $urandom_range(9);
      setup_req((pick < 4) ? REQ_SET_ADDRESS : (pick < 7) ? REQ_SET_CONFIG : $urandom,
                $urandom);
      if ($urandom_range(2) == 0) begin
         start_xfer(5'd0, $urandom_range(0, 200));
         guard = 0;
         while (tracker.left_bytes[0] != 0) begin
            if (guard == 8 && tracker.packet_cap[0] < 10'd512)
               set_packet(5'd0, 10'($urandom_range(512, 1023)));
            issue(rand_req(KIND_DONE, 5'd0));
            guard++;
         end
      end
      if ($urandom_range(9) < 7) finish_xfer(5'd0);
      if ($urandom_range(3) == 0) issue(rand_req(KIND_DONE, 5'd1));
   endtask

   task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
      int unsigned goal;
      int          pick;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      goal           = sent_items + PHASE_ITEMS;
      while (sent_items < goal) begin
         pick = $urandom_range(99);
         if (pick < 45)
            run_transfer($urandom);
         else if (pick < 75)
            run_control();
         else if (pick < 80)
            issue(rand_req(KIND_BUS_RESET, $urandom));
         else
            issue(rand_req($urandom_range(0, 7), $urandom));
      end
   endtask

   initial begin
      req_beat_t r;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      issue(rand_req(KIND_DONE, 5'd0));
      issue(rand_req(KIND_DONE, 5'd1));
      setup_req(REQ_SET_ADDRESS, 16'hffff);
      issue(rand_req(KIND_DONE, 5'd0));
      setup_req(REQ_SET_CONFIG, 16'h0000);
      setup_req(8'hff, 16'h0000);
      start_xfer(5'd2, 16'd10);
      issue(rand_req(KIND_DONE, 5'd2));
      start_xfer(5'd2, 16'd5);
      set_packet(5'd2, 10'd1023);
      issue(rand_req(KIND_DONE, 5'd2));
      r      = rand_req(KIND_DONE, 5'd2);
      r.rlen = 10'd1023;
      issue(r);
      r.rlen = 10'd0;
      issue(r);
      set_packet(5'd31, 10'd1023);
      start_xfer(5'd31, 16'hffff);
      issue(rand_req(KIND_DONE, 5'd31));
      set_packet(5'd1, 10'd0);
      start_xfer(5'd1, 16'd0);
      start_xfer(5'd0, 16'd0);
      issue(rand_req(KIND_BUS_RESET, 5'd0));
      setup_req(REQ_SET_ADDRESS, 16'h1200);
      issue(rand_req(KIND_BUS_RESET, 5'd31));
      issue(rand_req(KIND_DONE, 5'd0));
      issue('{kind: KIND_SPARE_MAX, ep: '1, len: '1, plim: '1, rlen: '1, code: '1,
              value: '1});
      issue('{kind: KIND_SPARE_MIN, ep: '0, len: '0, plim: '0, rlen: '0, code: '0,
              value: '0});

      run_phase(0, 0);
      run_phase(77, 0);
      run_phase(0, 77);
      run_phase(9, 9);

      push           <= 1'b0;
      recv_stall_pct  = 0;
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
